// File: hdl/dssm_pkg.sv
// Shared types, codes and defaults for the dual stack shared memory block.
`timescale 1ns / 1ps

package dssm_pkg;

   localparam int DEPTH_DEF     = 1024;
   localparam int WORD_BITS_DEF = 32;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 10;
   localparam int SIZE_W   = 11;
   localparam int CSR_W    = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;   // latch the request, launch the top-of-stack read
      logic exec;   // first cycle of execution
      logic scan;   // further search steps
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_search;
      logic scan_done;
   } sts_type;

endpackage

// File: hdl/dssm_ctrl.sv
// Controller state machine: sequences load, execute and search scan.
`timescale 1ns / 1ps

module dssm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dssm_pkg::sts_type sts,
   output dssm_pkg::cmd_type cmd,
   output logic              busy
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.op_search && !sts.scan_done) ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hdl/dssm_datapath.sv
// Datapath: shared word memory, stack counters, search pointer and result registers.
`timescale 1ns / 1ps

module dssm_datapath #(
   parameter int DEPTH     = dssm_pkg::DEPTH_DEF,
   parameter int WORD_BITS = dssm_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dssm_pkg::cmd_type                   cmd,
   output dssm_pkg::sts_type                   sts,
   input  logic [dssm_pkg::MODE_W-1:0]         req_mode,
   input  logic                                req_which_stack,
   input  logic signed [dssm_pkg::VALUE_W-1:0] req_value,
   input  logic                                csr_we,
   input  logic [dssm_pkg::CSR_W-1:0]          csr_wdata,
   output logic                                rsp_valid,
   output logic [dssm_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dssm_pkg::VALUE_W-1:0] rsp_data,
   output logic [dssm_pkg::INDEX_W-1:0]        rsp_found_index,
   output logic [dssm_pkg::SIZE_W-1:0]         rsp_stack_size,
   output logic                                rsp_stack_empty,
   output logic                                rsp_all_full
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CAP_W  = $clog2(DEPTH + 1);
   localparam int CLW    = (CAP_W > dssm_pkg::CSR_W) ? CAP_W : dssm_pkg::CSR_W;
   localparam int DW     = (WORD_BITS > dssm_pkg::VALUE_W) ? WORD_BITS : dssm_pkg::VALUE_W;
   localparam int IW     = (ADDR_W > dssm_pkg::INDEX_W) ? ADDR_W : dssm_pkg::INDEX_W;
   localparam int SW     = (CAP_W > dssm_pkg::SIZE_W) ? CAP_W : dssm_pkg::SIZE_W;

   logic [WORD_BITS-1:0] mem [DEPTH];

   logic [dssm_pkg::MODE_W-1:0] mode_ff;
   logic                        sel_ff;
   logic [WORD_BITS-1:0]        key_ff;
   logic [CAP_W-1:0]            count_a_ff, count_a_in;
   logic [CAP_W-1:0]            count_b_ff, count_b_in;
   logic [CAP_W-1:0]            cap_ff, cap_in;
   logic [ADDR_W-1:0]           ptr_ff, ptr_in;
   logic [CAP_W-1:0]            remain_ff, remain_in;
   logic [WORD_BITS-1:0]        rd_data_ff;

   logic                        rsp_valid_ff;
   logic [dssm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [dssm_pkg::VALUE_W-1:0]  data_ff, data_in;
   logic [dssm_pkg::INDEX_W-1:0]  found_ff, found_in;
   logic [dssm_pkg::SIZE_W-1:0]   size_ff;
   logic                          empty_ff, full_ff;

   logic                 finish;
   logic                 mem_we;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    top_addr;
   logic [ADDR_W-1:0]    ptr_step;
   logic signed [DW-1:0] value_ext;
   logic [DW-1:0]        rd_ext;
   logic [CLW-1:0]       csr_ext;
   logic                 match;
   logic                 scan_done;
   logic                 full_now;
   logic [CAP_W-1:0]     size_next;
   logic [CAP_W:0]       total_next;
   logic [IW-1:0]        ptr_ext;
   logic [SW-1:0]        size_ext;

   // top of the requested stack, taken from the request ports at accept time
   assign top_addr = req_which_stack ? ADDR_W'(cap_ff - count_b_ff)
                                     : ADDR_W'(count_a_ff - 1'b1);
   assign ptr_step = sel_ff ? ptr_ff + 1'b1 : ptr_ff - 1'b1;
   assign rd_addr  = cmd.load ? top_addr : ptr_step;

   assign value_ext = DW'(req_value);
   assign rd_ext    = DW'(rd_data_ff);
   assign csr_ext   = CLW'(csr_wdata);
   assign ptr_ext   = IW'(ptr_ff);

   assign match     = (rd_data_ff == key_ff);
   assign scan_done = (remain_ff == '0) || match || (remain_ff == CAP_W'(1));
   assign full_now  = ({1'b0, count_a_ff} + {1'b0, count_b_ff}) >= {1'b0, cap_ff};

   assign sts.op_search = (mode_ff == dssm_pkg::MODE_SEARCH);
   assign sts.scan_done = scan_done;

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      cap_in     = cap_ff;
      ptr_in     = ptr_ff;
      remain_in  = remain_ff;
      status_in  = dssm_pkg::ST_OK;
      data_in    = '0;
      found_in   = '0;
      finish     = 1'b0;
      mem_we     = 1'b0;
      wr_addr    = sel_ff ? ADDR_W'(cap_ff - 1'b1 - count_b_ff) : ADDR_W'(count_a_ff);

      if (csr_we) begin
         count_a_in = '0;
         count_b_in = '0;
         if (csr_ext == '0) begin
            cap_in = CAP_W'(1);
         end else if (csr_ext > CLW'(DEPTH)) begin
            cap_in = CAP_W'(DEPTH);
         end else begin
            cap_in = CAP_W'(csr_ext);
         end
      end else if (cmd.load) begin
         ptr_in    = top_addr;
         remain_in = req_which_stack ? count_b_ff : count_a_ff;
      end else if ((cmd.exec || cmd.scan) && sts.op_search) begin
         if (scan_done) begin
            finish = 1'b1;
            if (remain_ff != '0 && match) begin
               found_in = ptr_ext[dssm_pkg::INDEX_W-1:0];
            end else begin
               status_in = dssm_pkg::ST_NOT_FOUND;
            end
         end else begin
            ptr_in    = ptr_step;
            remain_in = remain_ff - 1'b1;
         end
      end else if (cmd.exec) begin
         finish = 1'b1;
         case (mode_ff)
            dssm_pkg::MODE_PUSH: begin
               if (full_now) begin
                  status_in = dssm_pkg::ST_FULL;
               end else begin
                  mem_we = 1'b1;
                  if (sel_ff) begin
                     count_b_in = count_b_ff + 1'b1;
                  end else begin
                     count_a_in = count_a_ff + 1'b1;
                  end
               end
            end
            dssm_pkg::MODE_POP, dssm_pkg::MODE_PEEK: begin
               if ((sel_ff ? count_b_ff : count_a_ff) == '0) begin
                  status_in = dssm_pkg::ST_EMPTY;
               end else begin
                  data_in = rd_ext[dssm_pkg::VALUE_W-1:0];
                  if (mode_ff == dssm_pkg::MODE_POP) begin
                     if (sel_ff) begin
                        count_b_in = count_b_ff - 1'b1;
                     end else begin
                        count_a_in = count_a_ff - 1'b1;
                     end
                  end
               end
            end
            dssm_pkg::MODE_CLEAR: begin
               if (sel_ff) begin
                  count_b_in = '0;
               end else begin
                  count_a_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign size_next  = sel_ff ? count_b_in : count_a_in;
   assign total_next = {1'b0, count_a_in} + {1'b0, count_b_in};
   assign size_ext   = SW'(size_next);

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= key_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         cap_ff       <= CAP_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         sel_ff  <= req_which_stack;
         key_ff  <= value_ext[WORD_BITS-1:0];
      end
      ptr_ff    <= ptr_in;
      remain_ff <= remain_in;
      if (finish) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         found_ff  <= found_in;
         size_ff   <= size_ext[dssm_pkg::SIZE_W-1:0];
         empty_ff  <= (size_next == '0);
         full_ff   <= (total_next >= {1'b0, cap_ff});
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data        = data_ff;
   assign rsp_found_index = found_ff;
   assign rsp_stack_size  = size_ff;
   assign rsp_stack_empty = empty_ff;
   assign rsp_all_full    = full_ff;

endmodule

// File: hdl/dual_stack_shared_memory.sv
// Top level: two stacks sharing one word memory, controller plus datapath.
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// -------   -------------------------------------   -----------------------------------
// request   req_mode, req_which_stack, req_value     beat taken when start & !busy
// response  rsp_status, rsp_data, rsp_found_index,  rsp_valid high one cycle per beat,
//           rsp_stack_size, rsp_stack_empty,        cannot be held off
//           rsp_all_full
// config    csr_wdata                               written when csr_we is high
//
// Push, pop, peek, clear and unused modes: the accept edge launches the top-of-stack
// read, and the execute state then computes and registers the result.
// Search compares entries from the top down until a match or the stack's end; the
// single memory read port compares one entry per cycle.
// Synchronous active-high reset clears both stacks and sets capacity to DEPTH; memory
// contents are left undefined. Writing capacity empties both stacks.
// The response side cannot stall; busy holds off the next request until the result
// shows, and a new beat is taken in the same cycle the result is on the ports.

module dual_stack_shared_memory #(
   parameter int DEPTH     = dssm_pkg::DEPTH_DEF,
   parameter int WORD_BITS = dssm_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dssm_pkg::MODE_W-1:0]         req_mode,
   input  logic                                req_which_stack,
   input  logic signed [dssm_pkg::VALUE_W-1:0] req_value,
   input  logic                                csr_we,
   input  logic [dssm_pkg::CSR_W-1:0]          csr_wdata,
   output logic                                rsp_valid,
   output logic [dssm_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dssm_pkg::VALUE_W-1:0] rsp_data,
   output logic [dssm_pkg::INDEX_W-1:0]        rsp_found_index,
   output logic [dssm_pkg::SIZE_W-1:0]         rsp_stack_size,
   output logic                                rsp_stack_empty,
   output logic                                rsp_all_full
);

   dssm_pkg::cmd_type cmd;
   dssm_pkg::sts_type sts;

   // sequence each beat: accept, execute, then scan while a search runs
   dssm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // hold memory, counters and result registers
   dssm_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_which_stack (req_which_stack),
      .req_value       (req_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_found_index (rsp_found_index),
      .rsp_stack_size  (rsp_stack_size),
      .rsp_stack_empty (rsp_stack_empty),
      .rsp_all_full    (rsp_all_full)
   );

endmodule

// File: hdl/dssm_checker.sv
// Port-level checks for the dual stack shared memory, bound to the top level.
`timescale 1ns / 1ps

module dssm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [dssm_pkg::MODE_W-1:0]         req_mode,
   input logic                                rsp_valid,
   input logic [dssm_pkg::STATUS_W-1:0]       rsp_status,
   input logic                                rsp_all_full
);

   // a taken beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   // anything but search answers straight from its execute state, with no scan
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode != dssm_pkg::MODE_SEARCH |=> ##1 rsp_valid)
      else $error("non-search beat missed its response slot");

   // results are single-cycle strobes, never back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // a result shows only once the block is free again
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // a refused push always reports the shared array as full
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dssm_pkg::ST_FULL |-> rsp_all_full)
      else $error("full status without full flag");

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_all_full (rsp_all_full)
);
